[rtl/upst_pkg.sv]
// shared types, widths and codes for the unique pair set table
`timescale 1ns / 1ps

package upst_pkg;

  // table geometry and field widths
  localparam int DEPTH       = 16;
  localparam int CMD_W       = 2;
  localparam int AREA_W      = 10;
  localparam int NUMBER_W    = 24;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int COUNT_SAT   = 31;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_AREA   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  // signals rippling from one cell to the next
  typedef struct packed {
    logic free_seen;
    logic pair_seen;
    logic area_seen;
  } chain_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic capture;
    logic do_add;
    logic do_remove;
  } cell_ctl_t;

  // per-cell status toward the sequencer
  typedef struct packed {
    logic valid;
    logic claim;
  } cell_stat_t;

  // clamp the entry count to the output field
  function automatic logic [COUNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [COUNT_OUT_W-1:0] r;
    if (int'(c) > COUNT_SAT) begin
      r = COUNT_OUT_W'(COUNT_SAT);
    end else begin
      r = COUNT_OUT_W'(c);
    end
    return r;
  endfunction

endpackage

[rtl/upst_cell.sv]
// one slot of the pair table with its compare and chain logic
`timescale 1ns / 1ps

module upst_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  upst_pkg::cell_ctl_t            ctl,
  input  logic [upst_pkg::AREA_W-1:0]    area_key,
  input  logic [upst_pkg::NUMBER_W-1:0]  number_key,
  input  upst_pkg::chain_t               chain_in,
  output upst_pkg::chain_t               chain_out,
  output upst_pkg::cell_stat_t           stat
);
  import upst_pkg::*;

  logic                valid;
  logic [AREA_W-1:0]   area;
  logic [NUMBER_W-1:0] number;
  logic                pair_hit;
  logic                claim;
  logic                area_match;
  logic                pair_match;
  logic                free_here;

  // slot compares
  assign area_match = valid && (area == area_key);
  assign pair_match = area_match && (number == number_key);
  assign free_here  = !valid;

  // lowest free slot claims, everything else ripples onward
  assign chain_out.free_seen = chain_in.free_seen || free_here;
  assign chain_out.pair_seen = chain_in.pair_seen || pair_match;
  assign chain_out.area_seen = chain_in.area_seen || area_match;

  // hold compare outcome for the update cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_hit <= 1'b0;
      claim    <= 1'b0;
    end else if (ctl.capture) begin
      pair_hit <= pair_match;
      claim    <= free_here && !chain_in.free_seen;
    end
  end

  // valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.do_add && claim) begin
      valid <= 1'b1;
    end else if (ctl.do_remove && pair_hit) begin
      valid <= 1'b0;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (ctl.do_add && claim) begin
      area   <= area_key;
      number <= number_key;
    end
  end

  assign stat.valid = valid;
  assign stat.claim = claim;

endmodule

[rtl/unique_pair_set_table.sv]
// Unique pair set table: a small set of (area code, number) pairs.
//
// Request channel (req_valid / req_stall) carries cmd, area_code and
// phone_number: add, remove, find or area query. Response channel
// (rsp_valid / rsp_stall) carries status, area_present and entry_count,
// one response per request, in order.
// A request is compared against all slots in the cycle after its transfer
// (state S_CMP); in state S_UPD the slots are updated and the response is
// registered. The next request can transfer in the same cycle the response
// is registered, so the table takes a new request while the last one
// finishes its update; each request passes the compare state, then the
// update state over the cell chain.
// While the response register is full and rsp_stall is high, the update
// cycle waits and req_stall stays high, so nothing is lost.
// Synchronous reset clears every slot valid mark, the entry count and both
// handshakes; slot contents are left as they are and never compared while
// their slot is empty.
`timescale 1ns / 1ps

module unique_pair_set_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [upst_pkg::CMD_W-1:0]          cmd,
  input  logic [upst_pkg::AREA_W-1:0]         area_code,
  input  logic [upst_pkg::NUMBER_W-1:0]       phone_number,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [upst_pkg::STATUS_W-1:0]       status,
  output logic                                area_present,
  output logic [upst_pkg::COUNT_OUT_W-1:0]    entry_count
);
  import upst_pkg::*;

  state_t              state;
  state_t              state_next;
  cmd_t                cmd_q;
  logic [AREA_W-1:0]   area_q;
  logic [NUMBER_W-1:0] number_q;
  logic                any_pair;
  logic                any_area;
  logic                any_free;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic                req_xfer;
  logic                upd_done;
  cell_ctl_t           ctl;
  chain_t              chain [DEPTH+1];
  logic [DEPTH-1:0]    valid_vec;
  logic [DEPTH-1:0]    claim_vec;
  status_t             status_calc;
  logic                present_calc;

  // handshakes
  assign upd_done  = (state == S_UPD) && (!rsp_valid || !rsp_stall);
  assign req_stall = (state == S_CMP) || ((state == S_UPD) && !upd_done);
  assign req_xfer  = req_valid && !req_stall;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_xfer) state_next = S_CMP;
      S_CMP:  state_next = S_UPD;
      S_UPD: begin
        if (upd_done) state_next = req_xfer ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cmd_q    <= cmd_t'(cmd);
      area_q   <= area_code;
      number_q <= phone_number;
    end
  end

  // cell controls
  assign ctl.capture   = (state == S_CMP);
  assign ctl.do_add    = upd_done && (cmd_q == CMD_ADD) && !any_pair && any_free;
  assign ctl.do_remove = upd_done && (cmd_q == CMD_REMOVE) && any_pair;

  // chain of slot cells
  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_stat_t st;
    upst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .area_key   (area_q),
      .number_key (number_q),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .stat       (st)
    );
    assign valid_vec[i] = st.valid;
    assign claim_vec[i] = st.claim;
  end

  // summary of the compare pass
  always_ff @(posedge clk) begin
    if (state == S_CMP) begin
      any_pair <= chain[DEPTH].pair_seen;
      any_area <= chain[DEPTH].area_seen;
      any_free <= chain[DEPTH].free_seen;
    end
  end

  // response fields
  always_comb begin
    status_calc  = ST_OK;
    present_calc = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        if (any_pair)       status_calc = ST_DUP;
        else if (!any_free) status_calc = ST_FULL;
      end
      CMD_REMOVE, CMD_FIND: begin
        if (!any_pair) status_calc = ST_MISS;
      end
      CMD_AREA: begin
        present_calc = any_area;
        if (!any_area) status_calc = ST_MISS;
      end
      default: status_calc = ST_MISS;
    endcase
  end

  // entry count
  always_comb begin
    cnt_next = cnt;
    if (ctl.do_add)         cnt_next = cnt + CNT_W'(1);
    else if (ctl.do_remove) cnt_next = cnt - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (upd_done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_done) begin
      status       <= status_calc;
      area_present <= present_calc;
      entry_count  <= sat_count(cnt_next);
    end
  end

  // count tracks the valid marks
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    int'(cnt) == $countones(valid_vec))
    else $error("entry count differs from valid slots");

  // at most one slot is picked for an insert
  a_single_claim: assert property (@(posedge clk) disable iff (rst)
    $onehot0(claim_vec))
    else $error("more than one slot claimed");

  // full is reported only when every slot is taken
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (int'(cnt) == DEPTH))
    else $error("full status with free slots");

  // an insert never lands without a free slot or when the pair already exists
  a_no_dup_insert: assert property (@(posedge clk) disable iff (rst)
    ctl.do_add |-> !any_pair && (claim_vec != '0))
    else $error("insert without a free slot or with a duplicate");

endmodule

[verif/pair_set_checker.sv]
// checker for the unique pair set table: tracks the stored pairs and compares every response
`timescale 1ns / 1ps

module pair_set_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  logic [upst_pkg::CMD_W-1:0]       cmd,
  input  logic [upst_pkg::AREA_W-1:0]      area_code,
  input  logic [upst_pkg::NUMBER_W-1:0]    phone_number,
  input  logic                             rsp_valid,
  input  logic                             rsp_stall,
  input  logic [upst_pkg::STATUS_W-1:0]    status,
  input  logic                             area_present,
  input  logic [upst_pkg::COUNT_OUT_W-1:0] entry_count,
  output int                               mismatches,
  output int                               awaiting
);
  import upst_pkg::*;

  typedef struct packed {
    status_t                status;
    logic                   area_present;
    logic [COUNT_OUT_W-1:0] entry_count;
  } response_t;

  // shadow copy of the table slots
  logic                held        [DEPTH];
  logic [AREA_W-1:0]   held_area   [DEPTH];
  logic [NUMBER_W-1:0] held_number [DEPTH];

  response_t pending_responses[$];
  int        errors = 0;

  assign mismatches = errors;

  // apply one command to the shadow table and return the response it yields
  function automatic response_t apply_command(input cmd_t op,
                                              input logic [AREA_W-1:0] area,
                                              input logic [NUMBER_W-1:0] num);
    response_t r;
    int        hit;
    int        free_slot;
    int        n;
    int        i;
    r.status       = ST_OK;
    r.area_present = 1'b0;
    hit            = -1;
    free_slot      = -1;
    for (i = 0; i < DEPTH; i++) begin
      if (held[i] && held_area[i] == area && held_number[i] == num && hit < 0) hit = i;
      if (!held[i] && free_slot < 0) free_slot = i;
    end
    case (op)
      CMD_ADD: begin
        // a duplicate wins over a full table
        if (hit >= 0) begin
          r.status = ST_DUP;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          held[free_slot]        = 1'b1;
          held_area[free_slot]   = area;
          held_number[free_slot] = num;
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          held[hit] = 1'b0;
        end
      end
      CMD_FIND: begin
        if (hit < 0) r.status = ST_MISS;
      end
      default: begin
        // area query ignores the number
        for (i = 0; i < DEPTH; i++) begin
          if (held[i] && held_area[i] == area) r.area_present = 1'b1;
        end
        if (!r.area_present) r.status = ST_MISS;
      end
    endcase
    n = 0;
    for (i = 0; i < DEPTH; i++) begin
      if (held[i]) n++;
    end
    if (n > COUNT_SAT) n = COUNT_SAT;
    r.entry_count = COUNT_OUT_W'(n);
    return r;
  endfunction

  // response check first, then the new request, so the oldest expectation is used
  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) held[i] = 1'b0;
      pending_responses.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: response transfer with none expected: status %0d count %0d",
                   $time, status, entry_count);
          errors++;
        end else begin
          want = pending_responses.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
            errors++;
          end
          if (area_present !== want.area_present) begin
            $display("%0t: area_present expected %0d, got %0d",
                     $time, want.area_present, area_present);
            errors++;
          end
          if (entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d, got %0d",
                     $time, want.entry_count, entry_count);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        pending_responses.push_back(apply_command(cmd_t'(cmd), area_code, phone_number));
      end
    end
    awaiting <= pending_responses.size();
  end

endmodule

[verif/testbench.sv]
// stimulus and verdict for the unique pair set table
`timescale 1ns / 1ps

module testbench;
  import upst_pkg::*;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   req_valid    = 1'b0;
  logic [CMD_W-1:0]       cmd          = '0;
  logic [AREA_W-1:0]      area_code    = '0;
  logic [NUMBER_W-1:0]    phone_number = '0;
  logic                   rsp_stall    = 1'b0;
  logic                   req_stall;
  logic                   rsp_valid;
  logic [STATUS_W-1:0]    status;
  logic                   area_present;
  logic [COUNT_OUT_W-1:0] entry_count;
  int                     mismatches;
  int                     awaiting;

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unique_pair_set_table DUT (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .area_code    (area_code),
    .phone_number (phone_number),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .area_present (area_present),
    .entry_count  (entry_count)
  );

  pair_set_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .area_code    (area_code),
    .phone_number (phone_number),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .area_present (area_present),
    .entry_count  (entry_count),
    .mismatches   (mismatches),
    .awaiting     (awaiting)
  );

  // receiver back-pressure, switching between quiet, light, heavy and toggling stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       rsp_stall <= 1'b0;
      1:       rsp_stall <= ($urandom_range(0, 99) < 30);
      2:       rsp_stall <= ($urandom_range(0, 99) < 85);
      default: rsp_stall <= ~rsp_stall;
    endcase
  end

  // one request transfer, sent in bursts with random gaps in between
  task automatic send_request(input cmd_t op, input logic [AREA_W-1:0] area,
                              input logic [NUMBER_W-1:0] num);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_valid    <= 1'b1;
    cmd          <= op;
    area_code    <= area;
    phone_number <= num;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [AREA_W-1:0]   areas       [4];
    logic [AREA_W-1:0]   pool_area   [24];
    logic [NUMBER_W-1:0] pool_number [24];
    logic [AREA_W-1:0]   area;
    logic [NUMBER_W-1:0] num;
    cmd_t                op;
    bit                  filling;
    int                  pick;
    int                  r;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table: every lookup misses
    send_request(CMD_FIND, '0, '0);
    send_request(CMD_AREA, '0, '0);
    send_request(CMD_REMOVE, '0, '0);

    // field extremes, duplicate add
    send_request(CMD_ADD, '0, '0);
    send_request(CMD_ADD, '1, '1);
    send_request(CMD_ADD, '0, '0);
    send_request(CMD_FIND, '1, '1);
    send_request(CMD_AREA, '1, NUMBER_W'(24'h5A5A5A));

    // remove hit, then remove of the same pair misses
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_REMOVE, '0, '0);

    // fill up, same area code with different numbers
    for (int k = 1; k <= DEPTH - 1; k++) begin
      send_request(CMD_ADD, '1, NUMBER_W'(k));
    end
    send_request(CMD_ADD, AREA_W'(5), NUMBER_W'(5));
    // duplicate on a full table reports duplicate
    send_request(CMD_ADD, '1, NUMBER_W'(1));

    // random phases over a small key pool, alternately filling and draining
    for (int phase = 0; phase < 12; phase++) begin
      for (int k = 0; k < 4; k++) areas[k] = AREA_W'($urandom_range(0, 1023));
      for (int k = 0; k < 24; k++) begin
        pool_area[k]   = areas[$urandom_range(0, 3)];
        pool_number[k] = $urandom_range(0, 1) ? NUMBER_W'($urandom)
                                              : NUMBER_W'($urandom_range(0, 15));
      end
      filling = (phase % 2 == 0);
      for (int n = 0; n < 130; n++) begin
        pick = $urandom_range(0, 23);
        area = pool_area[pick];
        num  = pool_number[pick];
        // occasional key from the whole field range
        if ($urandom_range(0, 9) == 0) begin
          area = AREA_W'($urandom);
          num  = NUMBER_W'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < (filling ? 55 : 15)) begin
          op = CMD_ADD;
        end else if (r < (filling ? 70 : 60)) begin
          op = CMD_REMOVE;
        end else if (r < 85) begin
          op = CMD_FIND;
        end else begin
          op  = CMD_AREA;
          num = NUMBER_W'($urandom);
        end
        send_request(op, area, num);
      end
    end

    // drain and settle
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
